@@ design/logistic_regression_trainer_macros.svh @@
// Assertion macros for the logistic regression trainer.
// Used by the top level only; needs nothing else.
`ifndef LOGISTIC_REGRESSION_TRAINER_MACROS_SVH
`define LOGISTIC_REGRESSION_TRAINER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, masked while reset is held
`define LRT_ASSERT_HOLDS(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, masked while reset is held
`define LRT_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRT_ASSERT_HOLDS(lbl, ck, rstn, ante, cons, msg)
`define LRT_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

@@ design/lrt_pkg.sv @@
// Shared types, widths, codes and the sigmoid table of the trainer.
// No dependencies; the design modules and the bench use it.
`timescale 1ns / 1ps

package lrt_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int FEAT_W  = 8;
  localparam int W_W     = 32;
  localparam int W_FRAC  = 24;
  localparam int LR_W    = 24;
  localparam int EC_W    = 20;

  localparam int SIG_ENTRIES = 1024;
  localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
  localparam int SIG_W       = 16;

  // error is Q1.16 signed in [-65535, 65536]
  localparam int ERR_W  = SIG_W + 2;
  localparam int WERR_W = ERR_W + FEAT_W;
  localparam int ESUM_W = ERR_W + ADDR_W;
  localparam int WSUM_W = WERR_W + ADDR_W;

  // z = w0 + w1 * feature
  localparam int Z_W = W_W + FEAT_W + 2;

  // step = round(lr * |sum| / (n << D_SHIFT))
  localparam int MAG_W     = WSUM_W - 1;
  localparam int MAG_LO_W  = 18;
  localparam int MAG_HI_W  = MAG_W - MAG_LO_W;
  localparam int D_SHIFT   = 40 - W_FRAC;
  localparam int P_W       = LR_W + MAG_W + 1;
  localparam int DIV_W     = P_W - D_SHIFT;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int STEP_W    = DIV_W + 1;
  localparam int UPD_W     = STEP_W + 1;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_COUNT   = CFG_IDX_W'(1);

  localparam logic [LR_W-1:0] LR_RESET = LR_W'(16777);
  localparam logic [EC_W-1:0] EC_RESET = EC_W'(500000);

  localparam logic signed [W_W-1:0] W_ONE = W_W'(1) << W_FRAC;
  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

  localparam longint SIG_LIM = longint'(8) << W_FRAC;
  localparam logic [ERR_W-1:0] LABEL_ONE = ERR_W'(65536);

  typedef struct packed {
    logic [FEAT_W-1:0] feature;
    logic              label;
  } sample_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    sample_t           data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EPOCH_START,
    ST_EPOCH_RUN,
    ST_STEP0_START,
    ST_STEP0_WAIT,
    ST_STEP1_START,
    ST_STEP1_WAIT,
    ST_EMIT
  } trainer_state_t;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_MUL_LO,
    SS_MUL_HI,
    SS_ADD,
    SS_DIV,
    SS_DONE
  } step_state_t;

  typedef logic [SIG_W-1:0] sig_rom_t [SIG_ENTRIES];

  // restoring long division for the table build
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-t in Q31 from a cubic on t/256, squared eight times
  function automatic logic [63:0] exp_neg_q31(logic [63:0] t);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] e;
    u  = t >> 8;
    u2 = (u * u) >> 31;
    u3 = (u2 * u) >> 31;
    e  = (64'd1 << 31) - u + (u2 >> 1) - div_u64(u3, 64'd6);
    for (int r = 0; r < 8; r++) begin
      e = (e * e) >> 31;
    end
    return e;
  endfunction

  function automatic logic [63:0] half_sigmoid(logic [63:0] k);
    logic [63:0] t;
    logic [63:0] d;
    t = div_u64((64'd16 * k) << 31, 64'(SIG_ENTRIES));
    d = (64'd1 << 31) + exp_neg_q31(t);
    return div_u64((64'd1 << 47) + (d >> 1), d);
  endfunction

  // evaluated once at elaboration
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] v;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      if (i >= SIG_ENTRIES / 2) begin
        v = half_sigmoid(64'(i - SIG_ENTRIES / 2));
      end else begin
        v = 64'd65536 - half_sigmoid(64'(SIG_ENTRIES / 2 - i));
      end
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      rom[i] = v[SIG_W-1:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

@@ design/logistic_regression_trainer.sv @@
// Logistic regression trainer, top level. Uses lrt_pkg, lrt_sample_mem,
// lrt_epoch_engine, lrt_step_unit and the assertion macro header.
// Input channel (in_*): one training sample per beat, feature and label; in_last
// closes the batch. Samples load at one beat per cycle while in_ready is high.
// Past 1024 stored samples a beat is dropped and the drop flag set; a last mark on
// it still starts training. in_ready stays low while training runs.
// Training: epoch_count epochs of batch gradient descent over the N stored
// samples. Each epoch makes N reads of the sample memory through a four-stage
// datapath, then two weight steps, each a split multiply and a bit-serial
// divide by N.
// Result channel (out_*): one beat per batch with both Q8.24 weights and the
// saturation and drop flags, held in an output register until out_ready. Loading
// of the next batch goes on while it waits; a finished training holds until the
// register is free.
// Configuration (cfg_*): learning rate (index 0) and epoch count (index 1);
// always ready, write only while idle.
// Reset: synchronous active-low rst_n clears the batch, sets both weights to 1.0
// and the registers to their defaults. The sample memory needs no clearing.
`timescale 1ns / 1ps
`include "logistic_regression_trainer_macros.svh"

module logistic_regression_trainer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lrt_pkg::FEAT_W-1:0]           in_feature,
  input  logic                                 in_label,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lrt_pkg::W_W-1:0]       out_intercept_weight,
  output logic signed [lrt_pkg::W_W-1:0]       out_slope_weight,
  output logic                                 out_weight_saturated,
  output logic                                 out_samples_dropped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lrt_pkg::LR_W-1:0]             cfg_data
);
  import lrt_pkg::*;

  trainer_state_t state_r, state_nxt;

  logic [LR_W-1:0]         lr_r;
  logic [EC_W-1:0]         epoch_count_r;
  logic [CNT_W-1:0]        sample_total_r;
  logic [EC_W-1:0]         epochs_done_r;
  logic signed [W_W-1:0]   w0_r, w1_r;
  logic                    sat_r, drop_r;
  logic                    out_valid_r;
  logic signed [W_W-1:0]   out_w0_r, out_w1_r;
  logic                    out_sat_r, out_drop_r;

  logic                    in_fire;
  logic                    full;
  logic                    eng_start, step_start, sel_slope, emit_go;
  logic [EC_W-1:0]         epochs_nxt;

  mem_wr_t                 mem_wr;
  mem_rd_t                 mem_rd;
  sample_t                 mem_rd_data;

  logic                    eng_done;
  logic signed [ESUM_W-1:0] esum;
  logic signed [WSUM_W-1:0] wsum;
  logic [ESUM_W-1:0]       eabs;
  logic [WSUM_W-1:0]       wabs;
  logic [MAG_W-1:0]        step_mag;
  logic                    step_neg;
  logic                    step_done;
  logic signed [STEP_W-1:0] step;

  logic signed [W_W-1:0]   w_sel;
  logic signed [UPD_W-1:0] upd_sum;
  logic                    upd_ovf;
  logic signed [W_W-1:0]   upd_w;

  assign in_fire    = in_valid & in_ready;
  assign full       = (sample_total_r == CNT_W'(MAX_SAMPLES));
  assign epochs_nxt = EC_W'(epochs_done_r + 1'b1);
  assign cfg_ready  = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = (epoch_count_r == '0) ? ST_EMIT : ST_EPOCH_START;
        end
      end
      ST_EPOCH_START: state_nxt = ST_EPOCH_RUN;
      ST_EPOCH_RUN:   if (eng_done) state_nxt = ST_STEP0_START;
      ST_STEP0_START: state_nxt = ST_STEP0_WAIT;
      ST_STEP0_WAIT:  if (step_done) state_nxt = ST_STEP1_START;
      ST_STEP1_START: state_nxt = ST_STEP1_WAIT;
      ST_STEP1_WAIT: begin
        if (step_done) begin
          state_nxt = (epochs_nxt == epoch_count_r) ? ST_EMIT : ST_EPOCH_START;
        end
      end
      ST_EMIT:        if (emit_go) state_nxt = ST_LOAD;
      default:        state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    eng_start  = 1'b0;
    step_start = 1'b0;
    sel_slope  = 1'b0;
    emit_go    = 1'b0;
    case (state_r)
      ST_LOAD:        in_ready = 1'b1;
      ST_EPOCH_START: eng_start = 1'b1;
      ST_STEP0_START: step_start = 1'b1;
      ST_STEP1_START: begin
        step_start = 1'b1;
        sel_slope  = 1'b1;
      end
      ST_STEP1_WAIT:  sel_slope = 1'b1;
      ST_EMIT:        emit_go = ~out_valid_r | out_ready;
      default: begin
      end
    endcase
  end

  assign mem_wr.en           = in_fire & ~full;
  assign mem_wr.addr         = sample_total_r[ADDR_W-1:0];
  assign mem_wr.data.feature = in_feature;
  assign mem_wr.data.label   = in_label;

  lrt_sample_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  lrt_epoch_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (eng_start),
    .n       (sample_total_r),
    .w0      (w0_r),
    .w1      (w1_r),
    .rd      (mem_rd),
    .rd_data (mem_rd_data),
    .done    (eng_done),
    .esum    (esum),
    .wsum    (wsum)
  );

  // sign and magnitude of the selected sum
  assign eabs     = esum[ESUM_W-1] ? ESUM_W'(-esum) : ESUM_W'(esum);
  assign wabs     = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
  assign step_mag = sel_slope ? MAG_W'(wabs) : MAG_W'(eabs);
  assign step_neg = sel_slope ? wsum[WSUM_W-1] : esum[ESUM_W-1];

  lrt_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .mag   (step_mag),
    .neg   (step_neg),
    .lr    (lr_r),
    .n     (sample_total_r),
    .done  (step_done),
    .step  (step)
  );

  // add the step and clip to the 32-bit range
  assign w_sel   = sel_slope ? w1_r : w0_r;
  assign upd_sum = UPD_W'(w_sel) + UPD_W'(step);
  assign upd_ovf = ~((&upd_sum[UPD_W-1:W_W-1]) | ~(|upd_sum[UPD_W-1:W_W-1]));
  assign upd_w   = upd_ovf ? (upd_sum[UPD_W-1] ? W_MIN : W_MAX) : upd_sum[W_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      lr_r           <= LR_RESET;
      epoch_count_r  <= EC_RESET;
      sample_total_r <= '0;
      epochs_done_r  <= '0;
      w0_r           <= W_ONE;
      w1_r           <= W_ONE;
      sat_r          <= 1'b0;
      drop_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LEARNING_RATE: lr_r <= cfg_data;
          CFG_EPOCH_COUNT:   epoch_count_r <= cfg_data[EC_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          sample_total_r <= CNT_W'(sample_total_r + 1'b1);
        end
      end
      if (step_done && state_r == ST_STEP0_WAIT) begin
        w0_r <= upd_w;
        if (upd_ovf) sat_r <= 1'b1;
      end
      if (step_done && state_r == ST_STEP1_WAIT) begin
        w1_r          <= upd_w;
        epochs_done_r <= epochs_nxt;
        if (upd_ovf) sat_r <= 1'b1;
      end
      // hand the result over and start the next batch
      if (emit_go) begin
        sample_total_r <= '0;
        epochs_done_r  <= '0;
        w0_r           <= W_ONE;
        w1_r           <= W_ONE;
        sat_r          <= 1'b0;
        drop_r         <= 1'b0;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_w0_r   <= w0_r;
      out_w1_r   <= w1_r;
      out_sat_r  <= sat_r;
      out_drop_r <= drop_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_intercept_weight = out_w0_r;
  assign out_slope_weight     = out_w1_r;
  assign out_weight_saturated = out_sat_r;
  assign out_samples_dropped  = out_drop_r;

  `LRT_ASSERT_HOLDS(a_total_bound, clk, rst_n, 1'b1, sample_total_r <= CNT_W'(MAX_SAMPLES), "sample count past capacity")
  `LRT_ASSERT_HOLDS(a_eng_done_state, clk, rst_n, eng_done, state_r == ST_EPOCH_RUN, "epoch done outside an epoch")
  `LRT_ASSERT_HOLDS(a_step_done_state, clk, rst_n, step_done, state_r == ST_STEP0_WAIT || state_r == ST_STEP1_WAIT, "step done while not waiting")
  `LRT_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_go, sample_total_r == '0 && epochs_done_r == '0 && out_valid_r, "batch not cleared after result")

endmodule

@@ design/lrt_sample_mem.sv @@
// Sample store: one write port for loading, one registered read port for training.
// Depends on lrt_pkg.
`timescale 1ns / 1ps

module lrt_sample_mem (
  input  logic             clk,
  input  lrt_pkg::mem_wr_t wr,
  input  lrt_pkg::mem_rd_t rd,
  output lrt_pkg::sample_t rd_data
);
  import lrt_pkg::*;

  sample_t mem [MAX_SAMPLES];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/lrt_epoch_engine.sv @@
// One pass over the stored samples: read, z, sigmoid lookup, error, accumulate.
// Depends on lrt_pkg; drives the read port of lrt_sample_mem.
`timescale 1ns / 1ps

module lrt_epoch_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lrt_pkg::CNT_W-1:0]           n,
  input  logic signed [lrt_pkg::W_W-1:0]      w0,
  input  logic signed [lrt_pkg::W_W-1:0]      w1,
  output lrt_pkg::mem_rd_t                    rd,
  input  lrt_pkg::sample_t                    rd_data,
  output logic                                done,
  output logic signed [lrt_pkg::ESUM_W-1:0]   esum,
  output logic signed [lrt_pkg::WSUM_W-1:0]   wsum
);
  import lrt_pkg::*;

  logic             issue_r;
  logic             busy_r;
  logic [CNT_W-1:0] idx_r;
  logic             v1_r, v2_r, v3_r, v4_r;

  logic signed [Z_W-1:0]      z_r;
  logic [FEAT_W-1:0]          x2_r, x3_r;
  logic                       lbl2_r, lbl3_r;
  logic [SIG_W-1:0]           sig3_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [WERR_W-1:0]   werr_r;
  logic signed [ESUM_W-1:0]   esum_r;
  logic signed [WSUM_W-1:0]   wsum_r;

  logic signed [W_W+FEAT_W:0] wx;
  logic signed [Z_W-1:0]      z_nxt;
  logic signed [Z_W-1:0]      zo;
  logic [SIG_BITS-1:0]        sig_idx;
  logic signed [ERR_W-1:0]    err_nxt;
  logic signed [WERR_W-1:0]   werr_nxt;

  assign rd.en   = issue_r;
  assign rd.addr = idx_r[ADDR_W-1:0];
  assign done    = busy_r & ~issue_r & ~v1_r & ~v2_r & ~v3_r & ~v4_r;
  assign esum    = esum_r;
  assign wsum    = wsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      busy_r  <= 1'b0;
      idx_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      if (start) begin
        issue_r <= (n != '0);
        busy_r  <= 1'b1;
        idx_r   <= '0;
      end else if (issue_r) begin
        idx_r <= CNT_W'(idx_r + 1'b1);
        if (CNT_W'(idx_r + 1'b1) == n) begin
          issue_r <= 1'b0;
        end
      end
      if (done) begin
        busy_r <= 1'b0;
      end
      v1_r <= issue_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // z = w0 + w1 * x
  assign wx    = w1 * $signed({1'b0, rd_data.feature});
  assign z_nxt = Z_W'(wx) + Z_W'(w0);

  // clamp z to the table range [-8, 8)
  always_comb begin
    zo = z_r + Z_W'(SIG_LIM);
    if (zo[Z_W-1]) begin
      sig_idx = '0;
    end else if (|zo[Z_W-2:W_FRAC+4]) begin
      sig_idx = '1;
    end else begin
      sig_idx = zo[W_FRAC+3 -: SIG_BITS];
    end
  end

  assign err_nxt  = $signed(lbl3_r ? LABEL_ONE : ERR_W'(0)) - $signed(ERR_W'(sig3_r));
  assign werr_nxt = err_nxt * $signed({1'b0, x3_r});

  always_ff @(posedge clk) begin
    z_r    <= z_nxt;
    x2_r   <= rd_data.feature;
    lbl2_r <= rd_data.label;
    sig3_r <= SIG_ROM[sig_idx];
    x3_r   <= x2_r;
    lbl3_r <= lbl2_r;
    err_r  <= err_nxt;
    werr_r <= werr_nxt;
    if (start) begin
      esum_r <= '0;
      wsum_r <= '0;
    end else if (v4_r) begin
      esum_r <= esum_r + ESUM_W'(err_r);
      wsum_r <= wsum_r + WSUM_W'(werr_r);
    end
  end

endmodule

@@ design/lrt_step_unit.sv @@
// Weight step: split multiply by the learning rate, then restoring divide by n.
// Depends on lrt_pkg.
`timescale 1ns / 1ps

module lrt_step_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lrt_pkg::MAG_W-1:0]         mag,
  input  logic                              neg,
  input  logic [lrt_pkg::LR_W-1:0]          lr,
  input  logic [lrt_pkg::CNT_W-1:0]         n,
  output logic                              done,
  output logic signed [lrt_pkg::STEP_W-1:0] step
);
  import lrt_pkg::*;

  step_state_t state_r, state_nxt;

  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [LR_W+MAG_LO_W-1:0] plo_r;
  logic [LR_W+MAG_HI_W-1:0] phi_r;
  logic [DIV_W-1:0]         quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic [DIV_CNT_W-1:0]     cnt_r;

  logic [P_W-1:0]           psum;
  logic [CNT_W:0]           trial_a;
  logic [CNT_W:0]           trial_d;
  logic signed [STEP_W-1:0] q_s;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SS_IDLE:   if (start) state_nxt = SS_MUL_LO;
      SS_MUL_LO: state_nxt = SS_MUL_HI;
      SS_MUL_HI: state_nxt = SS_ADD;
      SS_ADD:    state_nxt = SS_DIV;
      SS_DIV:    if (cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = SS_DONE;
      SS_DONE:   state_nxt = SS_IDLE;
      default:   state_nxt = SS_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      SS_DONE: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // lr * |sum| + d/2, with d = n << D_SHIFT
  assign psum = (P_W'(phi_r) << MAG_LO_W) + P_W'(plo_r) + (P_W'(n) << (D_SHIFT - 1));

  assign trial_a = {rem_r, quo_r[DIV_W-1]};
  assign trial_d = trial_a - {1'b0, n};

  always_ff @(posedge clk) begin
    case (state_r)
      SS_IDLE: begin
        mag_r <= mag;
        neg_r <= neg;
      end
      SS_MUL_LO: plo_r <= lr * mag_r[MAG_LO_W-1:0];
      SS_MUL_HI: phi_r <= lr * mag_r[MAG_W-1:MAG_LO_W];
      SS_ADD: begin
        quo_r <= psum[P_W-1:D_SHIFT];
        rem_r <= '0;
        cnt_r <= '0;
      end
      SS_DIV: begin
        // one quotient bit a cycle
        if (trial_d[CNT_W]) begin
          rem_r <= trial_a[CNT_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end else begin
          rem_r <= trial_d[CNT_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end
        cnt_r <= DIV_CNT_W'(cnt_r + 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign q_s  = $signed({1'b0, quo_r});
  assign step = neg_r ? -q_s : q_s;

endmodule

@@ bench/logistic_regression_trainer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for logistic_regression_trainer: sample batches, register
// writes and output back-pressure, checked against a fixed-point gradient-descent
// predictor kept in this file. Depends on lrt_pkg and the trainer RTL.

module logistic_regression_trainer_tb;

  localparam int SIG_N = 1024;
  localparam int FRAC = 24;
  localparam int MEM_DEPTH = 1024;
  localparam longint unsigned ONE_Q31 = 64'd1 << 31;
  localparam longint LABEL_ONE_Q16 = 65536;
  localparam longint W_TOP = 64'sd2147483647;
  localparam longint W_BOTTOM = -W_TOP - 1;
  localparam logic [23:0] RATE_AT_RESET = 24'd16777;
  localparam logic [19:0] EPOCHS_AT_RESET = 20'd500000;
  localparam logic [23:0] RATE_MAX = '1;
  localparam logic [19:0] EPOCHS_MAX = '1;
  localparam logic [lrt_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = lrt_pkg::CFG_IDX_W'(2);
  localparam logic [lrt_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES = 3000;
  localparam int QUIET_LIMIT = 60000;

  typedef struct packed {
    logic [lrt_pkg::FEAT_W-1:0] feature;
    logic                       label;
    logic                       last;
  } sample_beat_t;

  typedef struct packed {
    logic [lrt_pkg::W_W-1:0] intercept;
    logic [lrt_pkg::W_W-1:0] slope;
    logic                    saturated;
    logic                    dropped;
  } weights_t;

  typedef enum int {
    MIX_UNIFORM,
    MIX_SMALL_SPLIT,
    MIX_WIDE_SPLIT
  } batch_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [lrt_pkg::FEAT_W-1:0]        in_feature = '0;
  logic                              in_label = 1'b0;
  logic                              in_last = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [lrt_pkg::W_W-1:0]    out_intercept_weight;
  logic signed [lrt_pkg::W_W-1:0]    out_slope_weight;
  logic                              out_weight_saturated;
  logic                              out_samples_dropped;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lrt_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [lrt_pkg::LR_W-1:0]          cfg_data = '0;

  sample_beat_t pending_samples[$];
  weights_t     expected_weights[$];

  // predictor state
  logic [7:0]  batch_features [MEM_DEPTH];
  logic        batch_labels [MEM_DEPTH];
  int unsigned batch_len;
  bit          batch_dropped;
  logic [23:0] cur_rate;
  logic [19:0] cur_epochs;
  logic [15:0] sigmoid_tab [SIG_N];

  int unsigned tx_wait;
  bit          tx_burst;
  int unsigned rx_wait;
  bit          rx_burst;
  logic        hold_kick = 1'b0;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int          fail_count = 0;

  logistic_regression_trainer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_feature           (in_feature),
    .in_label             (in_label),
    .in_last              (in_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_intercept_weight (out_intercept_weight),
    .out_slope_weight     (out_slope_weight),
    .out_weight_saturated (out_weight_saturated),
    .out_samples_dropped  (out_samples_dropped),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // e^-t in Q31: cubic on t/256, then squared eight times
  function automatic longint unsigned exp_neg_fixed(longint unsigned t);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned e;
    u = t >> 8;
    u2 = (u * u) >> 31;
    u3 = (u2 * u) >> 31;
    e = ONE_Q31 - u + u2 / 2 - u3 / 6;
    repeat (8) e = (e * e) >> 31;
    return e;
  endfunction

  function automatic longint unsigned sigmoid_half(longint unsigned k);
    longint unsigned t;
    longint unsigned d;
    t = ((64'd16 * k) << 31) / SIG_N;
    d = ONE_Q31 + exp_neg_fixed(t);
    return ((64'd1 << 47) + d / 2) / d;
  endfunction

  function automatic logic [15:0] sigmoid_at(longint z);
    longint lim;
    longint idx;
    lim = longint'(8) << FRAC;
    if (z < -lim) return sigmoid_tab[0];
    if (z >= lim) return sigmoid_tab[SIG_N-1];
    idx = ((z + lim) * SIG_N) >> (FRAC + 4);
    return sigmoid_tab[idx];
  endfunction

  // round half away from zero of rate * |sum| / (n << 16), sign of sum
  function automatic longint weight_step(longint sum, int unsigned n);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    if (n == 0) return 0;
    mag = (sum < 0) ? -sum : sum;
    den = 64'(n) << (40 - FRAC);
    q = (64'(cur_rate) * mag + den / 2) / den;
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic weights_t train_batch();
    longint      w [2];
    longint      sum [2];
    longint      x;
    longint      err;
    bit          sat;
    int unsigned ep;
    int unsigned j;
    int unsigned k;
    weights_t    r;
    w[0] = longint'(1) << FRAC;
    w[1] = w[0];
    sat = 1'b0;
    for (ep = 0; ep < cur_epochs; ep++) begin
      sum[0] = 0;
      sum[1] = 0;
      for (j = 0; j < batch_len; j++) begin
        x = longint'(batch_features[j]);
        err = (batch_labels[j] ? LABEL_ONE_Q16 : longint'(0))
              - longint'(sigmoid_at(w[0] + w[1] * x));
        sum[0] += err;
        sum[1] += err * x;
      end
      // both steps come from this epoch's sums
      for (k = 0; k < 2; k++) begin
        w[k] = w[k] + weight_step(sum[k], batch_len);
        if (w[k] > W_TOP) begin
          w[k] = W_TOP;
          sat = 1'b1;
        end else if (w[k] < W_BOTTOM) begin
          w[k] = W_BOTTOM;
          sat = 1'b1;
        end
      end
    end
    r.intercept = 32'(w[0]);
    r.slope = 32'(w[1]);
    r.saturated = sat;
    r.dropped = batch_dropped;
    return r;
  endfunction

  always @(posedge clk) begin : weight_predictor
    if (!rst_n) begin
      batch_len = 0;
      batch_dropped = 1'b0;
      cur_rate = RATE_AT_RESET;
      cur_epochs = EPOCHS_AT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrt_pkg::CFG_LEARNING_RATE: cur_rate = cfg_data;
          lrt_pkg::CFG_EPOCH_COUNT:   cur_epochs = cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (batch_len < MEM_DEPTH) begin
          batch_features[batch_len] = in_feature;
          batch_labels[batch_len] = in_label;
          batch_len++;
        end else begin
          batch_dropped = 1'b1;
        end
        if (in_last) begin
          expected_weights.push_back(train_batch());
          batch_len = 0;
          batch_dropped = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sample_driver
    sample_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
      tx_burst <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_samples.size() != 0 && tx_wait == 0) begin
        nxt = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_feature <= nxt.feature;
        in_label <= nxt.label;
        in_last <= nxt.last;
        if ($urandom_range(0, 63) == 0) tx_burst <= !tx_burst;
        tx_wait <= tx_burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
        if (tx_wait != 0) tx_wait <= tx_wait - 1;
      end
    end
  end

  always @(posedge clk) begin : ready_driver
    int unsigned wait_next;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      rx_burst <= 1'b0;
    end else begin
      wait_next = rx_wait;
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 7) == 0) rx_burst <= !rx_burst;
        wait_next = rx_burst ? 0 : $urandom_range(0, 7);
      end else if (out_valid && rx_wait != 0) begin
        wait_next = rx_wait - 1;
      end
      rx_wait <= wait_next;
      out_ready <= (wait_next == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off, so finished trainings back up into the input
  always @(posedge clk) begin : ready_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : weight_monitor
    weights_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        $display("%0t: weight beat with none pending, expected nothing, got %h %h %b %b",
                 $time, out_intercept_weight, out_slope_weight,
                 out_weight_saturated, out_samples_dropped);
        fail_count++;
      end else begin
        want = expected_weights.pop_front();
        check_field("intercept_weight", want.intercept, out_intercept_weight);
        check_field("slope_weight", want.slope, out_slope_weight);
        check_field("weight_saturated", want.saturated, out_weight_saturated);
        check_field("samples_dropped", want.dropped, out_samples_dropped);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, no beat on any channel for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [lrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lrt_pkg::LR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_sample(input int unsigned f, input bit lbl, input bit lst);
    sample_beat_t b;
    b.feature = 8'(f);
    b.label = lbl;
    b.last = lst;
    pending_samples.push_back(b);
  endtask

  task automatic queue_batch(input int unsigned len);
    batch_mix_t  mix;
    int unsigned cut;
    int unsigned f;
    int unsigned i;
    bit          lbl;
    mix = batch_mix_t'($urandom_range(0, 2));
    cut = $urandom_range(0, 255);
    for (i = 0; i < len; i++) begin
      case (mix)
        MIX_UNIFORM: begin
          f = $urandom_range(0, 255);
          lbl = $urandom_range(0, 1);
        end
        MIX_SMALL_SPLIT: begin
          // small features with a threshold split on the labels; flip a few labels
          f = $urandom_range(0, 15);
          lbl = (f * 16 >= cut) ^ ($urandom_range(0, 9) == 0);
        end
        default: begin
          f = $urandom_range(0, 255);
          lbl = (f >= cut) ^ ($urandom_range(0, 19) == 0);
        end
      endcase
      queue_sample(f, lbl, i == len - 1);
    end
  endtask

  function automatic logic [23:0] random_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RATE_MAX;
      2: return RATE_AT_RESET;
      3: return 24'($urandom_range(0, 65535));
      4: return 24'($urandom_range(0, 1 << 20));
      default: return 24'($urandom);
    endcase
  endfunction

  // wait until every beat is sent and every weight beat is back, then idle a bit
  task automatic settle();
    while (pending_samples.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned     i;
    int unsigned     sent;
    int unsigned     nb;
    int unsigned     len;
    longint unsigned v;
    for (i = 0; i < SIG_N; i++) begin
      if (i >= SIG_N / 2) v = sigmoid_half(i - SIG_N / 2);
      else v = 64'd65536 - sigmoid_half(SIG_N / 2 - i);
      sigmoid_tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset learning rate, short run
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, 3);
    queue_sample(0, 0, 0);
    queue_sample(255, 1, 0);
    queue_sample(170, 1, 0);
    queue_sample(85, 0, 1);
    settle();

    // full-scale rate drives the slope into the clip
    write_reg(lrt_pkg::CFG_LEARNING_RATE, RATE_MAX);
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, 6);
    queue_sample(255, 0, 0);
    queue_sample(255, 0, 0);
    queue_sample(254, 0, 1);
    queue_sample(255, 0, 0);
    queue_sample(1, 1, 0);
    queue_sample(0, 1, 1);
    settle();

    // zero rate holds the start weights; single-sample batch
    write_reg(lrt_pkg::CFG_LEARNING_RATE, '0);
    queue_sample(7, 1, 1);
    settle();

    // unknown indexes must not touch either register
    write_reg(CFG_IDX_SPARE, RATE_MAX);
    write_reg(CFG_IDX_TOP, RATE_MAX);
    queue_sample(200, 0, 0);
    queue_sample(3, 1, 1);
    settle();

    // write the full-width count, then zero epochs
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, EPOCHS_MAX);
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, 0);
    queue_sample(128, 1, 0);
    queue_sample(64, 0, 1);
    settle();

    // a longer run on a separable set
    write_reg(lrt_pkg::CFG_LEARNING_RATE, 24'd1 << 20);
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, 40);
    for (i = 0; i <= 10; i += 2) queue_sample(i, i > 5, i == 10);
    settle();

    // output held off while several batches finish behind it
    write_reg(lrt_pkg::CFG_LEARNING_RATE, random_rate());
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, 1);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    repeat (8) queue_batch($urandom_range(3, 10));
    settle();

    // overfill the sample memory; the last mark lands on a dropped sample
    write_reg(lrt_pkg::CFG_LEARNING_RATE, random_rate());
    write_reg(lrt_pkg::CFG_EPOCH_COUNT, $urandom_range(1, 2));
    queue_batch(MEM_DEPTH + $urandom_range(1, 3));
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_reg(lrt_pkg::CFG_LEARNING_RATE, random_rate());
      write_reg(lrt_pkg::CFG_EPOCH_COUNT, $urandom_range(0, 9));
      nb = $urandom_range(2, 6);
      repeat (nb) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 24);
        queue_batch(len);
        sent += len;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
